[rtl/core/sam_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the sparse mat-vec block.
`timescale 1ns / 1ps

package sam_pkg;

  // Sizes of the stores.
  localparam int MAX_CELLS   = 64;
  localparam int MAX_ENTRIES = 256;

  localparam int CELL_AW  = $clog2(MAX_CELLS);
  localparam int ENTRY_AW = $clog2(MAX_ENTRIES);
  localparam int ENTRY_CW = ENTRY_AW + 1;

  // Field widths.
  localparam int CFG_W  = 7;
  localparam int FUNC_W = 3;
  localparam int IDX_W  = 6;
  localparam int VAL_W  = 32;
  localparam int ACC_W  = 48;
  localparam int FRAC_W = 16;

  // Item function codes.
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_VEC    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CONST  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RUN    = 3'd4;

  // One stored operator entry.
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] coef;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;      // a transfer of a load item happens now
    logic                acc_clr;   // drop all accumulator contents
    logic                ent_rd;    // read entry ent_idx
    logic                src_rd;    // read vector and accumulator for the held entry
    logic                mul_en;    // register the product
    logic                acc_wr;    // write back the updated accumulator
    logic                cell_rd;   // read accumulator and constant of cell_idx
    logic                out_load;  // load the result register
    logic                last;      // the loaded result closes the run
    logic [ENTRY_AW-1:0] ent_idx;
    logic [CELL_AW-1:0]  cell_idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ENTRY_CW-1:0] entry_count;
    logic [CFG_W-1:0]    cell_n;    // cells in use after clamping
    logic                ent_ok;    // held entry lies inside the cells in use
  } status_t;

endpackage

[rtl/core/sam_dp.sv]
// Datapath of the sparse mat-vec block: stores, multiplier, accumulator update and saturation.
`timescale 1ns / 1ps

module sam_dp import sam_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic [FUNC_W-1:0]       func,
  input  logic [IDX_W-1:0]        row_index,
  input  logic [IDX_W-1:0]        col_index,
  input  logic signed [VAL_W-1:0] value,
  input  cmd_t                    cmd,
  output status_t                 st,
  output logic [IDX_W-1:0]        cell_index,
  output logic signed [VAL_W-1:0] result_value,
  output logic                    saturated,
  output logic                    last
);

  logic [CFG_W-1:0]    cell_count;
  logic [ENTRY_CW-1:0] entry_count;
  logic                entry_full;

  logic [MAX_CELLS-1:0] vec_vld;
  logic [MAX_CELLS-1:0] off_vld;
  logic [MAX_CELLS-1:0] acc_vld;

  entry_t                  ent_mem [MAX_ENTRIES];
  logic [VAL_W-1:0]        vec_mem [MAX_CELLS];
  logic [VAL_W-1:0]        off_mem [MAX_CELLS];
  logic [ACC_W-1:0]        acc_mem [MAX_CELLS];

  entry_t                  ent_q;
  logic [VAL_W-1:0]        vec_rd;
  logic                    vec_rd_vld;
  logic [VAL_W-1:0]        off_rd;
  logic                    off_rd_vld;
  logic [ACC_W-1:0]        acc_rd;
  logic                    acc_rd_vld;
  logic [CELL_AW-1:0]      acc_raddr;

  logic signed [VAL_W-1:0]   coef_op;
  logic signed [VAL_W-1:0]   vec_op;
  logic signed [2*VAL_W-1:0] mul_full;
  logic [ACC_W-1:0]          prod_q;
  logic [ACC_W-1:0]          acc_op;
  logic [ACC_W-1:0]          acc_sum;
  logic [ACC_W-1:0]          off_ext;
  logic [ACC_W-1:0]          cell_sum;
  logic                      sum_hi_ones;
  logic                      sum_hi_zeros;
  logic                      wr_vec;
  logic                      wr_off;
  logic                      wr_ent;

  assign entry_full = (entry_count == ENTRY_CW'(MAX_ENTRIES));
  assign wr_ent     = cmd.load && (func == FUNC_APPEND) && !entry_full;
  assign wr_vec     = cmd.load && (func == FUNC_VEC);
  assign wr_off     = cmd.load && (func == FUNC_CONST);

  // Configuration and entry list length.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count  <= CFG_W'(MAX_CELLS);
      entry_count <= '0;
    end else begin
      if (cfg_we) begin
        cell_count <= cfg_data;
      end
      if (cmd.load && (func == FUNC_CLEAR)) begin
        entry_count <= '0;
      end else if (wr_ent) begin
        entry_count <= entry_count + ENTRY_CW'(1);
      end
    end
  end

  // Per-cell valid bits stand in for the zero reset of the cell stores.
  always_ff @(posedge clk) begin
    if (rst) begin
      vec_vld <= '0;
      off_vld <= '0;
      acc_vld <= '0;
    end else begin
      if (wr_vec) begin
        vec_vld[col_index[CELL_AW-1:0]] <= 1'b1;
      end
      if (wr_off) begin
        off_vld[row_index[CELL_AW-1:0]] <= 1'b1;
      end
      if (cmd.acc_clr) begin
        acc_vld <= '0;
      end else if (cmd.acc_wr) begin
        acc_vld[ent_q.row[CELL_AW-1:0]] <= 1'b1;
      end
    end
  end

  // Entry store.
  always_ff @(posedge clk) begin
    if (wr_ent) begin
      ent_mem[entry_count[ENTRY_AW-1:0]] <= '{row: row_index, col: col_index, coef: value};
    end
    if (cmd.ent_rd) begin
      ent_q <= ent_mem[cmd.ent_idx];
    end
  end

  // Vector store, read at the column of the held entry.
  always_ff @(posedge clk) begin
    if (wr_vec) begin
      vec_mem[col_index[CELL_AW-1:0]] <= value;
    end
    if (cmd.src_rd) begin
      vec_rd     <= vec_mem[ent_q.col[CELL_AW-1:0]];
      vec_rd_vld <= vec_vld[ent_q.col[CELL_AW-1:0]];
    end
  end

  // Constant store, read per output cell.
  always_ff @(posedge clk) begin
    if (wr_off) begin
      off_mem[row_index[CELL_AW-1:0]] <= value;
    end
    if (cmd.cell_rd) begin
      off_rd     <= off_mem[cmd.cell_idx];
      off_rd_vld <= off_vld[cmd.cell_idx];
    end
  end

  // Accumulator store: one read port shared by the entry walk and the output walk.
  assign acc_raddr = cmd.src_rd ? ent_q.row[CELL_AW-1:0] : cmd.cell_idx;

  always_ff @(posedge clk) begin
    if (cmd.acc_wr) begin
      acc_mem[ent_q.row[CELL_AW-1:0]] <= acc_sum;
    end
    if (cmd.src_rd || cmd.cell_rd) begin
      acc_rd     <= acc_mem[acc_raddr];
      acc_rd_vld <= acc_vld[acc_raddr];
    end
  end

  // Product of coefficient and vector element, truncated to Q32.16.
  assign coef_op  = $signed(ent_q.coef);
  assign vec_op   = vec_rd_vld ? $signed(vec_rd) : '0;
  assign mul_full = coef_op * vec_op;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_q <= mul_full[2*VAL_W-1:FRAC_W];
    end
  end

  assign acc_op  = acc_rd_vld ? acc_rd : '0;
  assign acc_sum = acc_op + prod_q;

  // Constant term and saturation to 32 bits.
  assign off_ext      = off_rd_vld ? {{(ACC_W-VAL_W){off_rd[VAL_W-1]}}, off_rd} : '0;
  assign cell_sum     = acc_op + off_ext;
  assign sum_hi_ones  = &cell_sum[ACC_W-1:VAL_W-1];
  assign sum_hi_zeros = ~|cell_sum[ACC_W-1:VAL_W-1];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cell_index <= IDX_W'(cmd.cell_idx);
      last       <= cmd.last;
      saturated  <= !(sum_hi_ones || sum_hi_zeros);
      if (sum_hi_ones || sum_hi_zeros) begin
        result_value <= cell_sum[VAL_W-1:0];
      end else if (cell_sum[ACC_W-1]) begin
        result_value <= {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
        result_value <= {1'b0, {(VAL_W-1){1'b1}}};
      end
    end
  end

  // Status back to the controller.
  always_comb begin
    st.entry_count = entry_count;
    if (cell_count == '0) begin
      st.cell_n = CFG_W'(1);
    end else if (cell_count > CFG_W'(MAX_CELLS)) begin
      st.cell_n = CFG_W'(MAX_CELLS);
    end else begin
      st.cell_n = cell_count;
    end
    st.ent_ok = (CFG_W'(ent_q.row) < st.cell_n) && (CFG_W'(ent_q.col) < st.cell_n);
  end

endmodule

[rtl/core/sam_ctrl.sv]
// Controller of the sparse mat-vec block: item intake, entry walk and output walk.
`timescale 1ns / 1ps

module sam_ctrl import sam_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] func,
  output logic              out_valid,
  input  logic              out_ready,
  input  status_t           st,
  output cmd_t              cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ENT_RD  = 3'd1;
  localparam logic [2:0] S_SRC_RD  = 3'd2;
  localparam logic [2:0] S_MUL     = 3'd3;
  localparam logic [2:0] S_ACC     = 3'd4;
  localparam logic [2:0] S_CELL_RD = 3'd5;
  localparam logic [2:0] S_SUM     = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [ENTRY_CW-1:0] k;
  logic [ENTRY_CW-1:0] k_next;
  logic [CELL_AW-1:0]  i;
  logic [CELL_AW-1:0]  i_next;
  logic                in_xfer;
  logic                last_ent;
  logic                last_cell;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign in_xfer   = in_valid && in_ready;
  assign last_ent  = (k + ENTRY_CW'(1)) == st.entry_count;
  assign last_cell = (CFG_W'(i) + CFG_W'(1)) == st.cell_n;

  always_comb begin
    state_next   = state;
    k_next       = k;
    i_next       = i;
    cmd          = '0;
    cmd.ent_idx  = k[ENTRY_AW-1:0];
    cmd.cell_idx = i;
    cmd.last     = last_cell;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (func == FUNC_RUN) begin
            cmd.acc_clr = 1'b1;
            k_next      = '0;
            i_next      = '0;
            state_next  = (st.entry_count == '0) ? S_CELL_RD : S_ENT_RD;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_ENT_RD: begin
        cmd.ent_rd = 1'b1;
        state_next = S_SRC_RD;
      end
      S_SRC_RD: begin
        if (st.ent_ok) begin
          cmd.src_rd = 1'b1;
          state_next = S_MUL;
        end else begin
          k_next     = k + ENTRY_CW'(1);
          state_next = last_ent ? S_CELL_RD : S_ENT_RD;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_wr = 1'b1;
        k_next     = k + ENTRY_CW'(1);
        state_next = last_ent ? S_CELL_RD : S_ENT_RD;
      end
      S_CELL_RD: begin
        cmd.cell_rd = 1'b1;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.out_load = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (last_cell) begin
            state_next = S_IDLE;
          end else begin
            i_next     = i + CELL_AW'(1);
            state_next = S_CELL_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      i     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      i     <= i_next;
    end
  end

  // The accumulator is only written the cycle after its product was registered.
  assert property (@(posedge clk) disable iff (rst) cmd.acc_wr |-> $past(cmd.mul_en))
    else $error("accumulator write without a fresh product");

  // The entry walk never reads beyond the stored list.
  assert property (@(posedge clk) disable iff (rst) (state == S_ENT_RD) |-> (k < st.entry_count))
    else $error("entry index beyond the list length");

  // A stalled result keeps its cell position.
  assert property (@(posedge clk) disable iff (rst)
      (state == S_OUT && !out_ready) |=> (state == S_OUT && $stable(i)))
    else $error("result dropped while stalled");

  // No item is taken while a result is pending.
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input taken during output walk");

endmodule

[rtl/core/sparse_affine_matvec_top.sv]
// Top level of the sparse affine matrix-vector block (out = A*u + b).
`timescale 1ns / 1ps

// The block holds a list of up to 256 (row, column, coefficient) entries, a
// 64-cell input vector u and 64 constant terms b, all signed Q16.16. Load items
// (clear list, append entry, write vector element, write constant) are applied
// as they are taken, without leaving the idle state, and a full list silently
// ignores further appends. A run item computes A*u + b over the cells in use
// (cfg_data, clamped to 1..64) and returns one result per cell in ascending
// order, with last set on the final one; entries that reference a cell outside
// the cells in use are skipped. Products are truncated toward minus infinity,
// sums wrap in 48 bits and each result is saturated to 32 bits with the
// saturated flag raised when clipping happened. The block works on one item at
// a time and takes no input while a run is in progress. In a run each entry
// inside the cells in use is a read of the entry store, a read of the vector and
// accumulator stores, a registered multiply and an accumulator write-back, a
// skipped entry costs only the entry read and the range check, and each cell is
// a store read, a saturating add and a result transfer, which may stall on
// out_ready. The user must see that configuration is written only while the
// block is idle; the block itself does not enforce this.

module sparse_affine_matvec_top import sam_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [FUNC_W-1:0]       func,
  input  logic [IDX_W-1:0]        row_index,
  input  logic [IDX_W-1:0]        col_index,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IDX_W-1:0]        cell_index,
  output logic signed [VAL_W-1:0] result_value,
  output logic                    saturated,
  output logic                    last
);

  // Commands and status between the controller and the datapath.
  cmd_t    cmd;
  status_t st;

  // The controller owns the handshakes and walks the entries and the cells.
  sam_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // The datapath holds the stores and the arithmetic, and the result register
  // that keeps a finished result steady until its transfer.
  sam_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .func         (func),
    .row_index    (row_index),
    .col_index    (col_index),
    .value        (value),
    .cmd          (cmd),
    .st           (st),
    .cell_index   (cell_index),
    .result_value (result_value),
    .saturated    (saturated),
    .last         (last)
  );

endmodule
